/* hw/rtl/tmlf_pkg.sv */
// Shared types and codes for the text message length framer.
// No dependencies; compiled first.
package tmlf_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_HDR_END = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED  = 2'd2;
  localparam logic [1:0] STATUS_BAD_LENGTH = 2'd3;

  // One received byte as handed to the parser
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } tmlf_byte_t;

  // One framing result
  typedef struct packed {
    logic [15:0] header_len;
    logic [15:0] payload_len;
    logic [1:0]  status;
  } tmlf_result_t;

endpackage

/* hw/rtl/tmlf_in_if.sv */
// Byte request channel of the framer: valid/ready plus one buffer byte.
// Depends on nothing.
interface tmlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

/* hw/rtl/tmlf_out_if.sv */
// Result channel of the framer: valid/ready plus header/payload length and status.
// Depends on nothing.
interface tmlf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_len;
  logic [15:0] payload_len;
  logic [1:0]  status;

  modport source (output valid, output header_len, output payload_len, output status,
                  input ready);
  modport sink   (input valid, input header_len, input payload_len, input status,
                  output ready);
endinterface

/* hw/rtl/tmlf_parser.sv */
// Per-byte framing state machine: state registers and next-state logic.
// Depends on tmlf_pkg.
module tmlf_parser #(
  parameter int unsigned MAX_BUFFER_BYTES = 65535
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  tmlf_pkg::tmlf_byte_t  byte_in,
  output tmlf_pkg::tmlf_result_t result
);

  localparam logic [15:0] CountLimit =
    16'((MAX_BUFFER_BYTES < 65535) ? MAX_BUFFER_BYTES : 65535);

  localparam logic [2:0] PhLine  = 3'd0;
  localparam logic [2:0] PhRun   = 3'd1;
  localparam logic [2:0] PhKey   = 3'd2;
  localparam logic [2:0] PhSep   = 3'd3;
  localparam logic [2:0] PhBlank = 3'd4;
  localparam logic [2:0] PhNum   = 3'd5;
  localparam logic [2:0] PhBody  = 3'd6;

  // sub-state codes held in sub_idx
  localparam logic [3:0] KeywordLen = 4'd14;
  localparam logic [3:0] NumDigit   = 4'd1;
  localparam logic [3:0] NumNeg     = 4'd2;
  localparam logic [3:0] BodyData   = 4'd0;
  localparam logic [3:0] BodyZeros  = 4'd1;
  localparam logic [3:0] BodyDone   = 4'd2;
  localparam logic [3:0] RunFirst   = 4'd1;
  localparam logic [3:0] RunMore    = 4'd2;

  localparam logic [30:0] ValueMax = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] position;
    logic [1:0]  term_count;
    logic        first_cr;
    logic        second_equal;
    logic [3:0]  sub_idx;
    logic        length_seen;
    logic [30:0] length_value;
    logic        length_error;
    logic [15:0] header_end;
    logic [30:0] body_remaining;
    logic [15:0] zero_run;
  } parser_state_t;

  localparam parser_state_t StateReset = '{
    phase: PhLine, position: '0, term_count: '0, first_cr: 1'b0,
    second_equal: 1'b0, sub_idx: '0, length_seen: 1'b0, length_value: '0,
    length_error: 1'b0, header_end: '0, body_remaining: '0, zero_run: '0};

  // lower-case "content-length"
  function automatic logic [7:0] kw_char(logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h63;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h6C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_term(logic [7:0] b);
    return (b == 8'h0D) || (b == 8'h0A);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic run_ends(parser_state_t s);
    return (s.term_count == 2'd3) || ((s.term_count == 2'd2) && s.second_equal);
  endfunction

  function automatic parser_state_t line_byte(parser_state_t s, logic [7:0] b);
    parser_state_t r;
    r = s;
    if (is_term(b)) begin
      r.phase        = PhRun;
      r.term_count   = 2'd1;
      r.first_cr     = (b == 8'h0D);
      r.second_equal = 1'b0;
      r.sub_idx      = RunFirst;
    end else begin
      r.phase = PhLine;
    end
    return r;
  endfunction

  function automatic parser_state_t enter_body(parser_state_t s, logic [15:0] at);
    parser_state_t r;
    r = s;
    r.header_end     = at;
    r.body_remaining = s.length_value;
    r.phase          = PhBody;
    r.sub_idx        = BodyData;
    return r;
  endfunction

  function automatic parser_state_t body_byte(parser_state_t s, logic [7:0] b);
    parser_state_t r;
    logic          consumed;
    r = s;
    consumed = 1'b0;
    if (r.sub_idx == BodyData) begin
      if (r.body_remaining != '0) begin
        r.body_remaining = r.body_remaining - 31'd1;
        consumed = 1'b1;
      end else begin
        r.sub_idx = BodyZeros;
      end
    end
    if (!consumed && r.sub_idx == BodyZeros) begin
      if (b == 8'h00) begin
        if (r.zero_run < CountLimit) r.zero_run = r.zero_run + 16'd1;
      end else begin
        r.sub_idx = BodyDone;
      end
    end
    return r;
  endfunction

  function automatic parser_state_t key_byte(parser_state_t s, logic [7:0] b);
    parser_state_t r;
    logic [7:0]    lo;
    r = s;
    lo = ((b >= 8'h41) && (b <= 8'h5A)) ? (b | 8'h20) : b;
    if ((s.sub_idx < KeywordLen) && (lo == kw_char(s.sub_idx))) begin
      r.sub_idx = s.sub_idx + 4'd1;
      if (r.sub_idx == KeywordLen) begin
        r.length_seen = 1'b1;
        r.phase       = PhSep;
        r.sub_idx     = '0;
      end
    end else begin
      r = line_byte(s, b);
    end
    return r;
  endfunction

  function automatic parser_state_t run_byte(parser_state_t s, logic [7:0] b);
    parser_state_t r;
    logic          blank;
    r = s;
    blank = (b == 8'h20) || (b == 8'h09);
    if (is_term(b) || (blank && s.term_count != 2'd3)) begin
      if (s.sub_idx == RunFirst) begin
        r.second_equal = is_term(b) && ((b == 8'h0D) == s.first_cr);
        r.sub_idx      = RunMore;
      end
      if (is_term(b) && s.term_count != 2'd3) r.term_count = s.term_count + 2'd1;
    end else if (run_ends(s)) begin
      r = body_byte(enter_body(s, s.position), b);
    end else if (!s.length_seen) begin
      r.phase   = PhKey;
      r.sub_idx = '0;
      r = key_byte(r, b);
    end else begin
      r = line_byte(s, b);
    end
    return r;
  endfunction

  function automatic parser_state_t finish_number(parser_state_t s);
    parser_state_t r;
    r = s;
    if ((s.sub_idx & NumDigit) == '0) r.length_error = 1'b1;
    if (((s.sub_idx & NumNeg) != '0) && (s.length_value != '0)) r.length_error = 1'b1;
    return r;
  endfunction

  function automatic parser_state_t blank_byte(parser_state_t s, logic [7:0] b);
    parser_state_t r;
    r = s;
    if ((b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C)) begin
      r.phase = PhBlank;
    end else if ((b == 8'h2B) || (b == 8'h2D)) begin
      r.phase   = PhNum;
      r.sub_idx = (b == 8'h2D) ? NumNeg : '0;
    end else if (is_digit(b)) begin
      r.phase        = PhNum;
      r.sub_idx      = NumDigit;
      r.length_value = 31'(b[3:0]);
    end else begin
      r.length_error = 1'b1;
      r = line_byte(r, b);
    end
    return r;
  endfunction

  function automatic parser_state_t num_byte(parser_state_t s, logic [7:0] b);
    parser_state_t r;
    logic [34:0]   prod;
    r = s;
    // 10*v + d overflows exactly when v > (max - d) / 10
    prod = (35'(s.length_value) * 35'd10) + 35'(b[3:0]);
    if (is_digit(b)) begin
      r.length_value = (prod > 35'(ValueMax)) ? ValueMax : prod[30:0];
      r.sub_idx      = s.sub_idx | NumDigit;
    end else begin
      r = line_byte(finish_number(s), b);
    end
    return r;
  endfunction

  parser_state_t state_r, state_nxt;
  parser_state_t stepped;
  parser_state_t closed;
  logic [31:0]   body_sum;

  always_comb begin
    unique case (state_r.phase)
      PhRun:   stepped = run_byte(state_r, byte_in.data_byte);
      PhKey:   stepped = key_byte(state_r, byte_in.data_byte);
      PhSep: begin
        if ((byte_in.data_byte == 8'h3A) || (byte_in.data_byte == 8'h20)) begin
          stepped = state_r;
        end else begin
          stepped = blank_byte(state_r, byte_in.data_byte);
        end
      end
      PhBlank: stepped = blank_byte(state_r, byte_in.data_byte);
      PhNum:   stepped = num_byte(state_r, byte_in.data_byte);
      PhBody:  stepped = body_byte(state_r, byte_in.data_byte);
      default: stepped = line_byte(state_r, byte_in.data_byte);
    endcase
    if (stepped.position < CountLimit) stepped.position = stepped.position + 16'd1;
  end

  // end-of-buffer wrap-up
  always_comb begin
    closed = stepped;
    priority if ((stepped.phase == PhSep) || (stepped.phase == PhBlank)) begin
      closed.length_error = 1'b1;
    end else if (stepped.phase == PhNum) begin
      closed = finish_number(stepped);
    end else if ((stepped.phase == PhRun) && run_ends(stepped)) begin
      closed = enter_body(stepped, stepped.position);
    end else begin
      closed = stepped;
    end
  end

  assign body_sum = 32'(closed.length_value) + 32'(closed.zero_run);

  always_comb begin
    result.header_len  = '0;
    result.payload_len = '0;
    priority if (closed.length_error) begin
      result.status = tmlf_pkg::STATUS_BAD_LENGTH;
    end else if (closed.phase == PhBody) begin
      if ((closed.sub_idx == BodyData) && (closed.body_remaining != '0)) begin
        result.status = tmlf_pkg::STATUS_TRUNCATED;
      end else begin
        result.status      = tmlf_pkg::STATUS_OK;
        result.header_len  = closed.header_end;
        result.payload_len = (body_sum > 32'd65535) ? 16'hFFFF : body_sum[15:0];
      end
    end else begin
      result.status = tmlf_pkg::STATUS_NO_HDR_END;
    end
  end

  assign state_nxt = byte_in.last ? StateReset : stepped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StateReset;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/text_message_length_framer.sv */
// Text message length framer: one result per buffer, at its last byte.
// Throughput: one byte per cycle; a last byte stalls on a full result register.
// Path: an accepted byte waits in the input register and is parsed when the
//   parser steps; a last byte's result is registered in the result register.
// Reset (rst_n low, synchronous): clears all framing state and both valid flags.
// Depends on tmlf_pkg, tmlf_in_if, tmlf_out_if, tmlf_parser.
module text_message_length_framer #(
  parameter int unsigned MAX_BUFFER_BYTES = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  tmlf_in_if.sink           in_chan,
  tmlf_out_if.source        out_chan
);

  // Input register: holds one accepted byte request until the parser takes it.
  logic                   in_valid_r;
  tmlf_pkg::tmlf_byte_t   in_byte_r;

  // Result register: holds a finished result until the sink takes it.
  logic                   out_valid_r;
  tmlf_pkg::tmlf_result_t out_res_r;

  tmlf_pkg::tmlf_result_t parser_res;
  logic                   step_en;

  // A byte that is not last never produces a result, so it always moves on.
  // A last byte needs the result register to be free or draining this cycle.
  assign step_en = in_valid_r && (!in_byte_r.last || !out_valid_r || out_chan.ready);

  // Input register reloads whenever it is empty or its byte is consumed.
  assign in_chan.ready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r.data_byte <= in_chan.data_byte;
      in_byte_r.last      <= in_chan.last;
    end
  end

  // Framing state machine; state returns to reset after each last byte.
  tmlf_parser #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .byte_in (in_byte_r),
    .result  (parser_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && in_byte_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && in_byte_r.last) begin
      out_res_r <= parser_res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.header_len  = out_res_r.header_len;
  assign out_chan.payload_len = out_res_r.payload_len;
  assign out_chan.status      = out_res_r.status;

  // Bytes in the middle of a buffer never stall in the input register.
  a_mid_byte_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !in_byte_r.last) |-> step_en)
    else $error("mid-buffer byte stalled");

  // A parsed last byte always shows up as a result on the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && in_byte_r.last) |=> out_valid_r)
    else $error("last byte produced no result");

  // Lengths are reported only with an ok status.
  a_err_zero_lengths: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status != tmlf_pkg::STATUS_OK)) |->
      ((out_res_r.header_len == '0) && (out_res_r.payload_len == '0)))
    else $error("nonzero length with error status");

endmodule
